// ===== rtl/core/cse_pkg.sv =====
// Shared types, constants and a helper function of the cosine similarity engine.
package cse_pkg;

   localparam int ACC_W  = 48;
   localparam int PROD_W = 32;
   localparam int SQ_W   = 64;
   localparam int DIV_STEPS = 30;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   // The three running sums of one vector pair
   typedef struct packed {
      logic signed [ACC_W-1:0] dot;
      logic [ACC_W-1:0]        norm_a;
      logic [ACC_W-1:0]        norm_b;
   } sums_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SQRT,
      B_MUL,
      B_CHECK,
      B_DIV,
      B_DONE
   } back_state_type;

   // Saturating add of a product onto a 48-bit accumulator
   function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0]  acc,
                                                       input logic signed [PROD_W-1:0] p);
      logic signed [ACC_W:0] s;
      s = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){p[PROD_W-1]}}, p};
      if (s[ACC_W] != s[ACC_W-1]) begin
         sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sat_add = s[ACC_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/cse_if.sv =====
// Valid/ready channel interfaces for element pairs and scores.
interface cse_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] elem_a;
   logic signed [15:0] elem_b;
   logic               last_pair;
   modport source(output valid, output elem_a, output elem_b, output last_pair, input ready);
   modport sink(input valid, input elem_a, input elem_b, input last_pair, output ready);
endinterface

interface cse_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] score;
   logic               zero_norm;
   modport source(output valid, output score, output zero_norm, input ready);
   modport sink(input valid, input score, input zero_norm, output ready);
endinterface

// ===== rtl/core/cse_front.sv =====
// Front end: element products and saturating running sums, one pair per cycle while space_ok is high.
module cse_front
   import cse_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      space_ok,
   cse_req_if.sink   req_chan,
   output logic      push,
   output sums_type  push_data
);

   logic                     accept;
   logic signed [PROD_W-1:0] p_ab_ff, p_aa_ff, p_bb_ff;
   logic                     v1_ff, last1_ff;
   sums_type                 acc_ff, acc_in;

   assign req_chan.ready = space_ok;
   assign accept = req_chan.valid && req_chan.ready;

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      last1_ff <= req_chan.last_pair;
      p_ab_ff  <= req_chan.elem_a * req_chan.elem_b;
      p_aa_ff  <= req_chan.elem_a * req_chan.elem_a;
      p_bb_ff  <= req_chan.elem_b * req_chan.elem_b;
   end

   // accumulate stage
   always_comb begin
      acc_in.dot    = sat_add(acc_ff.dot, p_ab_ff);
      acc_in.norm_a = sat_add(acc_ff.norm_a, p_aa_ff);
      acc_in.norm_b = sat_add(acc_ff.norm_b, p_bb_ff);
   end

   assign push      = v1_ff && last1_ff;
   assign push_data = acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (v1_ff) begin
         acc_ff <= last1_ff ? '0 : acc_in;
      end
   end

endmodule

// ===== rtl/core/cse_queue.sv =====
// Short FIFO of finished sums between the front and back ends.
module cse_queue
   import cse_pkg::*;
#(
   parameter int DEPTH = 4
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sums_type                   push_data,
   input  logic                       pop,
   output sums_type                   pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   sums_type               mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ff, rd_ff;
   logic [CNT_W-1:0]       count_ff;

   function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
      nxt = (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign pop_data = mem_ff[rd_ff];
   assign count    = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= nxt(wr_ff);
         if (pop)  rd_ff <= nxt(rd_ff);
         if (push && !pop)      count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - CNT_W'(1);
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// ===== rtl/core/cse_back.sv =====
// Back end: square roots, magnitude product, restoring divide and score format.
module cse_back
   import cse_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      mode,
   input  logic      q_valid,
   input  sums_type  q_data,
   output logic      q_pop,
   cse_rsp_if.source rsp_chan
);

   back_state_type    state_ff, state_in;
   sums_type          sums_ff;
   logic [SQ_W-1:0]   va_ff, vb_ff, ra_ff, rb_ff, bit_ff, m_ff, r_ff;
   logic [30:0]       q_ff, q_in;
   logic [4:0]        cnt_ff;
   logic              zn_ff, zero_in;
   logic signed [31:0] score_ff;
   logic [ACC_W-1:0]  mag;
   logic [SQ_W-1:0]   ta, tb, r_start;
   logic [SQ_W:0]     r2;
   logic signed [32:0] sim, distance;

   assign zero_in = (q_data.norm_a == '0) || (q_data.norm_b == '0);
   assign mag     = sums_ff.dot[ACC_W-1] ? ACC_W'(-sums_ff.dot) : ACC_W'(sums_ff.dot);
   assign r_start = {mag, 16'h0};
   assign ta      = ra_ff + bit_ff;
   assign tb      = rb_ff + bit_ff;
   assign r2      = {r_ff, 1'b0};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  if (q_valid) state_in = zero_in ? B_DONE : B_SQRT;
         B_SQRT:  if (bit_ff[0]) state_in = B_MUL;
         B_MUL:   state_in = B_CHECK;
         B_CHECK: state_in = (m_ff == '0 || r_start >= m_ff) ? B_DONE : B_DIV;
         B_DIV:   if (cnt_ff == 5'(DIV_STEPS-1)) state_in = B_DONE;
         B_DONE:  if (rsp_chan.ready) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop              = 1'b0;
      rsp_chan.valid     = 1'b0;
      case (state_ff)
         B_IDLE:  q_pop = q_valid;
         B_DONE:  rsp_chan.valid = 1'b1;
         default: ;
      endcase
   end

   assign rsp_chan.score     = score_ff;
   assign rsp_chan.zero_norm = zn_ff;

   // next quotient: range shortcut in CHECK, one restoring step per DIV cycle
   always_comb begin
      q_in = q_ff;
      case (state_ff)
         B_CHECK: begin
            if (m_ff == '0) q_in = (mag != '0) ? ONE_Q30 : '0;
            else if (r_start >= m_ff) q_in = ONE_Q30;
         end
         B_DIV:   q_in = {q_ff[29:0], (r2 >= {1'b0, m_ff})};
         default: ;
      endcase
   end

   // score from the next quotient, with sign and mode
   always_comb begin
      sim      = sums_ff.dot[ACC_W-1] ? -$signed({2'b00, q_in}) : $signed({2'b00, q_in});
      distance = $signed({2'b00, ONE_Q30}) - sim;
      if (distance[32] == 1'b0 && distance[31] == 1'b1) distance = 33'sh0_7FFF_FFFF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            sums_ff <= q_data;
            va_ff   <= {q_data.norm_a, 16'h0};
            vb_ff   <= {q_data.norm_b, 16'h0};
            ra_ff   <= '0;
            rb_ff   <= '0;
            bit_ff  <= SQ_W'(64'h4000_0000_0000_0000);
            zn_ff   <= zero_in;
            q_ff    <= '0;
            score_ff <= mode ? $signed({1'b0, ONE_Q30}) : 32'sd0;
         end
         B_SQRT: begin
            if (va_ff >= ta) begin
               va_ff <= va_ff - ta;
               ra_ff <= (ra_ff >> 1) + bit_ff;
            end else begin
               ra_ff <= ra_ff >> 1;
            end
            if (vb_ff >= tb) begin
               vb_ff <= vb_ff - tb;
               rb_ff <= (rb_ff >> 1) + bit_ff;
            end else begin
               rb_ff <= rb_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         B_MUL: begin
            m_ff <= ra_ff[31:0] * rb_ff[31:0];
         end
         B_CHECK: begin
            r_ff   <= r_start;
            cnt_ff <= '0;
            q_ff   <= q_in;
         end
         B_DIV: begin
            cnt_ff <= cnt_ff + 5'd1;
            q_ff   <= q_in;
            if (r2 >= {1'b0, m_ff}) begin
               r_ff <= SQ_W'(r2 - {1'b0, m_ff});
            end else begin
               r_ff <= r2[SQ_W-1:0];
            end
         end
         default: ;
      endcase
      // latch the formatted score on entry to the result state
      if (state_ff != B_IDLE && state_ff != B_DONE && state_in == B_DONE) begin
         score_ff <= mode ? distance[31:0] : sim[31:0];
      end
   end

endmodule

// ===== rtl/core/cosine_similarity_engine_unit.sv =====
// Top level of the cosine similarity engine.
// Element pairs (signed Q4.12) are taken one per cycle with no stall while the
// result queue has room; the pair flagged last closes the vector and one
// signed Q2.30 score follows. The back end computes the two square roots, then
// the magnitude product, then the range check and, unless that check settles
// the quotient, the restoring divide; a zero norm skips straight to its fallback
// score. Up to QUEUE_DEPTH finished vectors wait between the two ends, so short
// vectors stall the input only when that queue has fewer than two free slots.
module cosine_similarity_engine_unit
   import cse_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)(
   input  logic      clock,
   input  logic      reset,
   cse_req_if.sink   req_chan,
   cse_rsp_if.source rsp_chan,
   input  logic      csr_we,
   input  logic      csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

   logic             mode_ff;
   logic             push, pop, space_ok;
   sums_type         push_data, pop_data;
   logic [CNT_W-1:0] count;

   // metric mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // leave one slot for the transaction in the product stage
   assign space_ok = count <= CNT_W'(QUEUE_DEPTH-2);

   cse_front u_front (
      .clock(clock), .reset(reset), .space_ok(space_ok), .req_chan(req_chan),
      .push(push), .push_data(push_data)
   );

   cse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .pop(pop), .pop_data(pop_data), .count(count)
   );

   cse_back u_back (
      .clock(clock), .reset(reset), .mode(mode_ff), .q_valid(count != '0),
      .q_data(pop_data), .q_pop(pop), .rsp_chan(rsp_chan)
   );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the cosine similarity engine: random element streams, predicted scores.
module tb;
   import cse_pkg::*;

   localparam longint SUM_MAX   = 64'sd140737488355327;
   localparam longint SUM_MIN   = -SUM_MAX - 1;
   localparam longint Q30_ONE   = 64'sd1073741824;
   localparam int     CYCLE_CAP = 3000000;
   localparam int     SETTLE    = 120;

   typedef struct {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic               last;
   } pair_type;

   typedef struct {
      logic signed [31:0] score;
      logic               zero_norm;
   } score_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_wdata = 1'b0;

   cse_req_if req_chan();
   cse_rsp_if rsp_chan();

   cosine_similarity_engine_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // bench copy of the block state
   logic   mode_q = 1'b0;
   longint dot_acc = 0;
   longint na_acc = 0;
   longint nb_acc = 0;

   pair_type  pairs_q[$];
   score_type scores_q[$];
   int     errors = 0;
   int     n_pairs = 0;
   int     n_scores = 0;
   int     n_zero = 0;
   longint cycles = 0;
   logic   hold_req = 1'b0;

   function automatic longint clamp_sum(input longint s);
      if (s > SUM_MAX) return SUM_MAX;
      if (s < SUM_MIN) return SUM_MIN;
      return s;
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // score of the finished vector pair from the current sums
   function automatic score_type vector_score();
      score_type   r;
      logic [63:0] sa, sb, m, mag, q;
      logic [64:0] rem;
      longint      sim, s;
      logic        neg;
      sim = 0;
      r.zero_norm = 1'b0;
      if (na_acc <= 0 || nb_acc <= 0) begin
         r.zero_norm = 1'b1;
      end else begin
         sa  = floor_sqrt(64'(na_acc) << 16);
         sb  = floor_sqrt(64'(nb_acc) << 16);
         m   = sa * sb;
         neg = dot_acc < 0;
         mag = neg ? 64'(-dot_acc) : 64'(dot_acc);
         rem = {1'b0, mag << 16};
         if (m == 0) begin
            q = (mag != 0) ? 64'(Q30_ONE) : 64'd0;
         end else if (rem >= {1'b0, m}) begin
            q = 64'(Q30_ONE);
         end else begin
            q = 0;
            for (int i = 0; i < 30; i++) begin
               rem = rem << 1;
               q   = q << 1;
               if (rem >= {1'b0, m}) begin
                  rem  = rem - {1'b0, m};
                  q[0] = 1'b1;
               end
            end
         end
         sim = neg ? -longint'(q) : longint'(q);
      end
      if (mode_q) begin
         s = Q30_ONE - sim;
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < 0) s = 0;
      end else begin
         s = sim;
      end
      r.score = s[31:0];
      return r;
   endfunction

   // fold one accepted pair into the sums; closing pair yields a score
   task automatic absorb_pair(input pair_type p);
      longint a, b;
      a = p.a;
      b = p.b;
      dot_acc = clamp_sum(dot_acc + a * b);
      na_acc  = clamp_sum(na_acc + a * a);
      nb_acc  = clamp_sum(nb_acc + b * b);
      if (p.last) begin
         scores_q.push_back(vector_score());
         dot_acc = 0;
         na_acc  = 0;
         nb_acc  = 0;
      end
   endtask

   // driver: bursts of transactions with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid     <= 1'b0;
         req_chan.elem_a    <= '0;
         req_chan.elem_b    <= '0;
         req_chan.last_pair <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            absorb_pair(pairs_q.pop_front());
            n_pairs++;
         end
         if (req_chan.valid && !req_chan.ready) begin
            // offered transaction waits unchanged
         end else if (gap_left > 0 || pairs_q.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.valid     <= 1'b1;
            req_chan.elem_a    <= pairs_q[0].a;
            req_chan.elem_b    <= pairs_q[0].b;
            req_chan.last_pair <= pairs_q[0].last;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // long receiver hold-off, counted here
   int hold_left = 0;
   logic hold_seen = 1'b0;
   always @(posedge clock) begin
      if (hold_req && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_left <= 600;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver stall pattern: calm and choppy stretches alternate
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
      end else if ((cycles / 700) % 2 == 0) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // monitor: compare each score transaction with the oldest prediction
   always @(posedge clock) begin
      score_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (scores_q.size() == 0) begin
            $error("unexpected score transaction: score %0d", rsp_chan.score);
            errors++;
         end else begin
            want = scores_q.pop_front();
            n_scores++;
            if (want.zero_norm) n_zero++;
            if (rsp_chan.score !== want.score) begin
               $error("score: expected %0d, actual %0d", want.score, rsp_chan.score);
               errors++;
            end
            if (rsp_chan.zero_norm !== want.zero_norm) begin
               $error("zero_norm: expected %0d, actual %0d", want.zero_norm,
                      rsp_chan.zero_norm);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic pair_type mk(input int a, input int b, input logic last);
      pair_type p;
      p.a    = a[15:0];
      p.b    = b[15:0];
      p.last = last;
      return p;
   endfunction

   function automatic logic [15:0] rand_elem(input int style);
      case (style)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 31) - 16);
         2: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(0, 8191) - 4096);
      endcase
   endfunction

   task automatic queue_random_vectors(input int total);
      int          len, style, rel, done;
      logic [15:0] a, b;
      done = 0;
      while (done < total) begin
         len   = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
         style = $urandom_range(0, 3);
         rel   = $urandom_range(0, 5);
         for (int i = 0; i < len; i++) begin
            a = rand_elem(style);
            b = rand_elem(style);
            case (rel)
               0: b = a;
               1: b = -a;
               2: a = 0;
               default: ;
            endcase
            if ($urandom_range(0, 30) == 0) b = 0;
            pairs_q.push_back(mk($signed(a), $signed(b), i == len - 1));
         end
         done += len;
      end
   endtask

   task automatic drain();
      wait (pairs_q.size() == 0 && scores_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mode(input logic v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      mode_q = v;
   endtask

   task automatic queue_directed();
      pairs_q.push_back(mk(-32768, -32768, 1'b1));
      pairs_q.push_back(mk(32767, -32768, 1'b1));
      pairs_q.push_back(mk(32767, 32767, 1'b1));
      pairs_q.push_back(mk(1234, -1234, 1'b1));
      pairs_q.push_back(mk(0, 500, 1'b1));
      pairs_q.push_back(mk(500, 0, 1'b1));
      pairs_q.push_back(mk(0, 0, 1'b1));
      pairs_q.push_back(mk(1, 1, 1'b0));
      pairs_q.push_back(mk(-1, 1, 1'b1));
      pairs_q.push_back(mk(4096, 0, 1'b0));
      pairs_q.push_back(mk(0, 4096, 1'b1));
      pairs_q.push_back(mk(1, -1, 1'b1));
   endtask

   initial begin
      csr_we    = 1'b0;
      csr_wdata = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // extremes and fallbacks in both modes
      queue_directed();
      drain();
      write_mode(1'b1);
      queue_directed();
      drain();

      // long vector of full-scale elements: large sums
      write_mode(1'b0);
      for (int i = 0; i < 200; i++)
         pairs_q.push_back(mk(-32768, (i % 3 == 0) ? 32767 : -32768, i == 199));
      drain();

      // random phases, the first one with the long hold-off
      for (int ph = 0; ph < 4; ph++) begin
         write_mode(ph[0]);
         if (ph == 0) hold_req = 1'b1;
         queue_random_vectors(350);
         drain();
      end
      write_mode(1'b0);

      $display("covered %0d pairs and %0d scores (%0d zero-norm) in both metric modes,",
               n_pairs, n_scores, n_zero);
      $display("including full-scale elements and a long receiver hold-off");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
